>>> rtl/vbi4_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbi4_pkg
// Shared types and constants of the vertex bone-influence store.
// ----------------------------------------------------------------------------
package vbi4_pkg;
    localparam int VERTEX_COUNT = 4096;
    localparam int VID_W = $clog2(VERTEX_COUNT);
    localparam int FRAC_BITS = 16;
    localparam int W_W = FRAC_BITS + 1;
    localparam int BONE_W = 8;
    localparam int SQ_W = 2 * W_W + 2;
    localparam int MAG_W = SQ_W / 2;
    localparam int NUM_W = W_W + FRAC_BITS + 1;
    localparam logic [W_W-1:0] W_ONE = W_W'(1) << FRAC_BITS;

    localparam logic [1:0] ACT_FILLED = 2'd0;
    localparam logic [1:0] ACT_REPLACED = 2'd1;
    localparam logic [1:0] ACT_DROPPED = 2'd2;
    localparam logic [1:0] ACT_CLEARED = 2'd3;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic [W_W-1:0] weight_0;
        logic [W_W-1:0] weight_1;
        logic [W_W-1:0] weight_2;
        logic [W_W-1:0] weight_3;
        logic [BONE_W-1:0] bone_0;
        logic [BONE_W-1:0] bone_1;
        logic [BONE_W-1:0] bone_2;
        logic [BONE_W-1:0] bone_3;
        logic [1:0] action;
    } res_t;

    typedef struct packed {
        logic op;
        logic [VID_W-1:0] vertex_id;
        logic [BONE_W-1:0] bone_id;
        logic [W_W-1:0] weight;
    } item_t;

    typedef struct packed {
        logic start;
        logic busy;
    } ctl_t;
endpackage
`default_nettype wire

>>> rtl/vbi4_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbi4_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface vbi4_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/vbi4_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbi4_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module vbi4_sqrt
    import vbi4_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ctl_t             ctl_in,
    input  wire logic [SQ_W-1:0]  radicand,
    output logic                  done,
    output logic [MAG_W-1:0]      root
);
    localparam int CNT_W = $clog2(MAG_W + 1);
    logic [SQ_W-1:0]  x_reg, x_next;
    logic [MAG_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W+1:0] trial;
    logic [MAG_W+1:0] shifted;

    always_comb
    begin
        x_next = x_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        cnt_next = cnt_reg;
        shifted = {rem_reg, x_reg[SQ_W-1 -: 2]};
        trial = {root_reg, 2'b01};
        if (ctl_in.start)
        begin
            x_next = radicand;
            rem_next = '0;
            root_next = '0;
            cnt_next = CNT_W'(MAG_W);
        end
        else if (cnt_reg != '0)
        begin
            x_next = x_reg << 2;
            cnt_next = cnt_reg - 1'b1;
            if (shifted >= trial)
            begin
                rem_next = MAG_W'(shifted - trial);
                root_next = {root_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = MAG_W'(shifted);
                root_next = {root_reg[MAG_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
    end

    assign done = ctl_in.busy && cnt_reg == '0;
    assign root = root_reg;
endmodule
`default_nettype wire

>>> rtl/vbi4_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbi4_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vbi4_div
    import vbi4_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ctl_t             ctl_in,
    input  wire logic [NUM_W-1:0] numer,
    input  wire logic [MAG_W-1:0] denom,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] q_reg, q_next;
    logic [MAG_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W:0]   sh;

    always_comb
    begin
        q_next = q_reg;
        rem_next = rem_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        sh = {rem_reg, q_reg[NUM_W-1]};
        if (ctl_in.start)
        begin
            q_next = numer;
            rem_next = '0;
            d_next = denom;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (sh >= {1'b0, d_reg})
            begin
                rem_next = MAG_W'(sh - {1'b0, d_reg});
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = MAG_W'(sh);
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        d_reg <= d_next;
    end

    assign done = ctl_in.busy && cnt_reg == '0;
    assign quot = q_reg;
endmodule
`default_nettype wire

>>> rtl/vertex_bone_influence_top4_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_bone_influence_top4_core
// Four-slot bone-influence store per vertex with replacement and
// renormalization.
// ----------------------------------------------------------------------------
// After reset the block sweeps its slot memory, one vertex row per cycle, and
// takes no transfer until that is done. A clear passes through the read,
// decode, write and output states from accepted input to result, a fill or a
// drop also through the slot-selection state. A replacement renormalizes the
// four weights: the sum of squares is built one weight at a time on one
// multiplier, then the bit-serial square root runs, and then the bit-serial
// divider runs once per weight. One item is handled at a time.
module vertex_bone_influence_top4_core
    import vbi4_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    vbi4_if.sink      in_ch,
    vbi4_if.source    out_ch
);
    localparam logic [3:0] ST_CLR     = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_READ    = 4'd2;
    localparam logic [3:0] ST_DEC     = 4'd3;
    localparam logic [3:0] ST_SQ      = 4'd4;
    localparam logic [3:0] ST_SQRT    = 4'd5;
    localparam logic [3:0] ST_DIV     = 4'd6;
    localparam logic [3:0] ST_WRITE   = 4'd7;
    localparam logic [3:0] ST_OUT     = 4'd8;
    localparam logic [3:0] ST_ROOT_GO = 4'd9;
    localparam logic [3:0] ST_ROOT    = 4'd10;
    localparam logic [3:0] ST_DIV_GO  = 4'd11;
    localparam int ROW_W = 4 * (W_W + BONE_W);

    logic [3:0] state_reg, state_next;
    logic [VID_W-1:0] clr_reg, clr_next;
    item_t item_reg, item_next;
    logic [W_W-1:0] w_reg [4];
    logic [W_W-1:0] w_next [4];
    logic [BONE_W-1:0] b_reg [4];
    logic [BONE_W-1:0] b_next [4];
    logic [1:0] act_reg, act_next;
    logic [1:0] idx_reg, idx_next;
    logic [SQ_W-1:0] sum_reg, sum_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic ovalid_reg, ovalid_next;
    res_t res_reg, res_next;
    logic [ROW_W-1:0] mem [VERTEX_COUNT];
    logic [ROW_W-1:0] rd_reg;
    logic mem_we;
    logic [VID_W-1:0] mem_addr;
    logic [ROW_W-1:0] mem_wd;
    ctl_t sq_ctl, dv_ctl;
    logic sq_done, dv_done;
    logic [MAG_W-1:0] sq_root;
    logic [NUM_W-1:0] dv_quot;
    logic [NUM_W-1:0] numer;
    logic [2*W_W-1:0] sq_prod;
    logic [W_W-1:0] w_in;
    logic [W_W-1:0] sel_w;
    logic [1:0] empty_idx, low_idx;
    logic has_empty, found;
    logic [W_W-1:0] lowest;

    assign sel_w = w_reg[idx_reg];
    assign sq_prod = sel_w * sel_w;
    assign numer = NUM_W'({sel_w, FRAC_BITS'(0)}) + NUM_W'(mag_reg >> 1);
    assign w_in = (item_reg.weight > W_ONE) ? W_ONE : item_reg.weight;

    always_comb
    begin
        has_empty = 1'b0;
        empty_idx = '0;
        for (int s = 3; s >= 0; s--)
        begin
            if (w_reg[s] == '0)
            begin
                has_empty = 1'b1;
                empty_idx = 2'(s);
            end
        end
        found = 1'b0;
        low_idx = '0;
        lowest = w_in;
        for (int s = 0; s < 4; s++)
        begin
            if (w_reg[s] < lowest)
            begin
                lowest = w_reg[s];
                low_idx = 2'(s);
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        item_next = item_reg;
        w_next = w_reg;
        b_next = b_reg;
        act_next = act_reg;
        idx_next = idx_reg;
        sum_next = sum_reg;
        mag_next = mag_reg;
        ovalid_next = ovalid_reg;
        res_next = res_reg;
        mem_we = 1'b0;
        mem_addr = item_reg.vertex_id;
        mem_wd = '0;
        sq_ctl = '{start: 1'b0, busy: 1'b0};
        dv_ctl = '{start: 1'b0, busy: 1'b0};
        if (ovalid_reg && out_ch.ready)
            ovalid_next = 1'b0;
        unique case (state_reg)
            ST_CLR:
            begin
                mem_we = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == VID_W'(VERTEX_COUNT - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    item_next = in_ch.data;
                    state_next = ST_READ;
                end
            end
            ST_READ:
                state_next = ST_DEC;
            ST_DEC:
            begin
                for (int s = 0; s < 4; s++)
                begin
                    w_next[s] = rd_reg[ROW_W-1-s*W_W -: W_W];
                    b_next[s] = rd_reg[4*BONE_W-1-s*BONE_W -: BONE_W];
                end
                state_next = ST_WRITE;
                if (item_reg.op == OP_CLEAR)
                begin
                    for (int s = 0; s < 4; s++)
                    begin
                        w_next[s] = '0;
                        b_next[s] = '0;
                    end
                    act_next = ACT_CLEARED;
                end
                else
                    state_next = ST_SQ;
            end
            ST_SQ:
            begin
                idx_next = '0;
                sum_next = '0;
                state_next = ST_WRITE;
                if (has_empty)
                begin
                    w_next[empty_idx] = w_in;
                    b_next[empty_idx] = item_reg.bone_id;
                    act_next = ACT_FILLED;
                end
                else if (found)
                begin
                    w_next[low_idx] = w_in;
                    b_next[low_idx] = item_reg.bone_id;
                    act_next = ACT_REPLACED;
                    state_next = ST_SQRT;
                end
                else
                    act_next = ACT_DROPPED;
            end
            ST_SQRT:
            begin
                sum_next = sum_reg + SQ_W'(sq_prod);
                idx_next = idx_reg + 1'b1;
                if (idx_reg == 2'd3)
                    state_next = ST_ROOT_GO;
            end
            ST_ROOT_GO:
            begin
                sq_ctl.start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                sq_ctl.busy = 1'b1;
                if (sq_done)
                begin
                    mag_next = sq_root;
                    idx_next = '0;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                if (mag_reg == '0)
                    state_next = ST_WRITE;
                else
                begin
                    dv_ctl.start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                dv_ctl.busy = 1'b1;
                if (dv_done)
                begin
                    w_next[idx_reg] = (dv_quot > NUM_W'(W_ONE)) ? W_ONE : W_W'(dv_quot);
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 2'd3)
                        state_next = ST_WRITE;
                    else
                        state_next = ST_DIV_GO;
                end
            end
            ST_WRITE:
            begin
                mem_we = 1'b1;
                mem_wd = {w_reg[0], w_reg[1], w_reg[2], w_reg[3],
                          b_reg[0], b_reg[1], b_reg[2], b_reg[3]};
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next = 1'b1;
                    res_next = '{weight_0: w_reg[0], weight_1: w_reg[1],
                                 weight_2: w_reg[2], weight_3: w_reg[3],
                                 bone_0: b_reg[0], bone_1: b_reg[1],
                                 bone_2: b_reg[2], bone_3: b_reg[3],
                                 action: act_reg};
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            clr_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        w_reg <= w_next;
        b_reg <= b_next;
        act_reg <= act_next;
        idx_reg <= idx_next;
        sum_reg <= sum_next;
        mag_reg <= mag_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wd;
        rd_reg <= mem[mem_addr];
    end

    vbi4_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (sq_ctl),
        .radicand (sum_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    vbi4_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (dv_ctl),
        .numer  (numer),
        .denom  (mag_reg),
        .done   (dv_done),
        .quot   (dv_quot)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data = res_reg;

    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLR |-> !in_ch.ready)
        else $error("input taken during memory sweep");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_reg))
        else $error("result changed while stalled");
    a_result_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> state_reg == ST_READ)
        else $error("accepted item not started");
endmodule
`default_nettype wire
